FILE: src/wasl_pkg.sv
`timescale 1ns / 1ps

package wasl_pkg;

  localparam int POSITION_BITS = 32;
  localparam int OFF_W = 32;
  localparam int LEN_W = 33;
  localparam int TDATA_W = 168;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WEBP = 32'h5042_4557;
  localparam logic [31:0] TAG_VP8X = 32'h5838_5056;
  localparam logic [31:0] TAG_ANMF = 32'h464D_4E41;
  localparam logic [31:0] TAG_ALPH = 32'h4850_4C41;
  localparam logic [31:0] TAG_VP8 = 32'h2038_5056;
  localparam logic [31:0] TAG_VP8L = 32'h4C38_5056;

  localparam logic [7:0] ANIM_FLAG = 8'h02;
  localparam logic [31:0] FRAME_HDR = 32'd16;
  localparam logic [LEN_W-1:0] CHUNK_HDR = 33'd8;
  localparam logic [LEN_W-1:0] STILL_HDR = 33'd12;

  localparam logic [POSITION_BITS-1:0] IDX_RIFF_TAG = 3;
  localparam logic [POSITION_BITS-1:0] IDX_RIFF_SIZE = 7;
  localparam logic [POSITION_BITS-1:0] IDX_WEBP_TAG = 11;
  localparam logic [POSITION_BITS-1:0] IDX_VP8X_TAG = 15;
  localparam logic [POSITION_BITS-1:0] IDX_VP8X_SIZE = 19;
  localparam logic [POSITION_BITS-1:0] IDX_VP8X_FLAGS = 20;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_OUTER,
    PH_SUB,
    PH_DONE,
    PH_NOTWEBP,
    PH_OVERFLOW
  } phase_t;

  typedef enum logic [1:0] {
    ST_NOT_ANIM = 2'd0,
    ST_FOUND    = 2'd1,
    ST_FAILED   = 2'd2
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0] total_length;
    logic [LEN_W-1:0] body_length;
    logic [OFF_W-1:0] body_offset;
    logic [LEN_W-1:0] alpha_length;
    logic [OFF_W-1:0] alpha_offset;
    status_t          status;
  } result_t;

endpackage

FILE: src/wasl_core.sv
`timescale 1ns / 1ps

module wasl_core import wasl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       last,
  output result_t    result
);

  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [LEN_W-1:0]         riff_end, riff_end_next;
  logic [55:0]              shift, shift_next;
  phase_t                   phase, phase_next;
  logic [LEN_W-1:0]         outer_hdr, outer_hdr_next;
  logic [LEN_W-1:0]         frame_end, frame_end_next;
  logic [LEN_W-1:0]         sub_hdr, sub_hdr_next;
  logic                     prefix_ok, prefix_ok_next;
  logic [OFF_W-1:0]         alpha_off, alpha_off_next;
  logic [LEN_W-1:0]         alpha_len, alpha_len_next;
  logic [OFF_W-1:0]         body_off, body_off_next;
  logic [LEN_W-1:0]         body_size, body_size_next;
  logic                     body_found, body_found_next;
  logic                     scan_failed, scan_failed_next;

  logic [63:0]      window;
  logic [31:0]      hi;
  logic [31:0]      lo;
  logic [LEN_W-1:0] idx_w;
  logic [LEN_W-1:0] chunk_sum;
  logic [LEN_W-1:0] chunk_next_hdr;
  logic [LEN_W-1:0] vp8x_sum;
  logic [LEN_W-1:0] vp8x_next_hdr;

  // The window holds the eight most recent bytes, the current one on top.
  assign window = {byte_in, shift};
  assign hi = window[63:32];
  assign lo = window[31:0];
  assign idx_w = LEN_W'(pos);
  assign chunk_sum = idx_w + LEN_W'(hi) + LEN_W'(1);
  assign chunk_next_hdr = chunk_sum + LEN_W'(hi[0]) + LEN_W'(7);
  assign vp8x_sum = LEN_W'(hi) + LEN_W'(IDX_VP8X_FLAGS);
  assign vp8x_next_hdr = vp8x_sum + LEN_W'(hi[0]) + LEN_W'(7);

  always_comb begin
    pos_next = pos;
    riff_end_next = riff_end;
    shift_next = shift;
    phase_next = phase;
    outer_hdr_next = outer_hdr;
    frame_end_next = frame_end;
    sub_hdr_next = sub_hdr;
    prefix_ok_next = prefix_ok;
    alpha_off_next = alpha_off;
    alpha_len_next = alpha_len;
    body_off_next = body_off;
    body_size_next = body_size;
    body_found_next = body_found;
    scan_failed_next = scan_failed;
    if (phase != PH_OVERFLOW) begin
      if (pos == POS_MAX) begin
        phase_next = PH_OVERFLOW;
      end else begin
        pos_next = pos + POSITION_BITS'(1);
        shift_next = window[63:8];
        unique case (phase)
          PH_PREFIX: begin
            if (pos == IDX_RIFF_TAG && hi != TAG_RIFF) begin
              prefix_ok_next = 1'b0;
            end
            if (pos == IDX_RIFF_SIZE) begin
              riff_end_next = LEN_W'(hi) + CHUNK_HDR;
            end
            if (pos == IDX_WEBP_TAG && hi != TAG_WEBP) begin
              prefix_ok_next = 1'b0;
            end
            if (pos == IDX_VP8X_TAG && hi != TAG_VP8X) begin
              prefix_ok_next = 1'b0;
            end
            if (pos == IDX_VP8X_SIZE) begin
              if (vp8x_sum > riff_end) begin
                scan_failed_next = 1'b1;
              end else begin
                outer_hdr_next = vp8x_next_hdr;
              end
            end
            if (pos == IDX_VP8X_FLAGS) begin
              if (prefix_ok && (byte_in & ANIM_FLAG) != 8'd0) begin
                phase_next = scan_failed ? PH_DONE : PH_OUTER;
              end else begin
                phase_next = PH_NOTWEBP;
              end
            end
          end
          PH_OUTER: begin
            if (idx_w == outer_hdr) begin
              if (chunk_sum > riff_end) begin
                phase_next = PH_DONE;
              end else if (lo == TAG_ANMF) begin
                if (hi <= FRAME_HDR) begin
                  phase_next = PH_DONE;
                end else begin
                  frame_end_next = chunk_sum;
                  sub_hdr_next = idx_w + LEN_W'(24);
                  phase_next = PH_SUB;
                end
              end else begin
                outer_hdr_next = chunk_next_hdr;
              end
            end
          end
          PH_SUB: begin
            if (idx_w == sub_hdr) begin
              if (chunk_sum > frame_end) begin
                phase_next = PH_DONE;
              end else if (lo == TAG_ALPH) begin
                alpha_off_next = OFF_W'(pos - POSITION_BITS'(7));
                alpha_len_next = LEN_W'(hi) + CHUNK_HDR;
                sub_hdr_next = chunk_next_hdr;
              end else if (lo == TAG_VP8 || lo == TAG_VP8L) begin
                body_off_next = OFF_W'(pos - POSITION_BITS'(7));
                body_size_next = LEN_W'(hi) + CHUNK_HDR;
                body_found_next = 1'b1;
                phase_next = PH_DONE;
              end else begin
                sub_hdr_next = chunk_next_hdr;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    result = '0;
    result.status = ST_FAILED;
    if (phase_next == PH_PREFIX || phase_next == PH_NOTWEBP) begin
      result.status = ST_NOT_ANIM;
    end else if (phase_next != PH_OVERFLOW && body_found_next &&
                 frame_end_next <= idx_w + LEN_W'(1)) begin
      result.status = ST_FOUND;
      result.alpha_offset = alpha_off_next;
      result.alpha_length = alpha_len_next;
      result.body_offset = body_off_next;
      result.body_length = body_size_next;
      result.total_length = STILL_HDR + alpha_len_next + body_size_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      pos <= '0;
      riff_end <= '0;
      shift <= '0;
      phase <= PH_PREFIX;
      outer_hdr <= '0;
      frame_end <= '0;
      sub_hdr <= '0;
      prefix_ok <= 1'b1;
      alpha_off <= '0;
      alpha_len <= '0;
      body_off <= '0;
      body_size <= '0;
      body_found <= 1'b0;
      scan_failed <= 1'b0;
    end else if (step) begin
      pos <= pos_next;
      riff_end <= riff_end_next;
      shift <= shift_next;
      phase <= phase_next;
      outer_hdr <= outer_hdr_next;
      frame_end <= frame_end_next;
      sub_hdr <= sub_hdr_next;
      prefix_ok <= prefix_ok_next;
      alpha_off <= alpha_off_next;
      alpha_len <= alpha_len_next;
      body_off <= body_off_next;
      body_size <= body_size_next;
      body_found <= body_found_next;
      scan_failed <= scan_failed_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && last |=> pos == '0 && phase == PH_PREFIX && !body_found)
    else $error("parser state not cleared after the final byte");

  a_overflow_holds_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_OVERFLOW |-> pos == POS_MAX)
    else $error("overflow phase entered below the position limit");

  a_body_ends_walk: assert property (@(posedge clk) disable iff (rst)
    body_found |-> phase == PH_DONE || phase == PH_OVERFLOW)
    else $error("walk continued after the body subchunk");
`endif

endmodule

FILE: src/webp_animation_still_locator.sv
`timescale 1ns / 1ps

// Locates the first still frame of an animated WebP file.
// The input stream carries the file one byte per request on s_tdata, with
// s_tlast high on the final byte. The block checks the RIFF/WEBP/VP8X prefix
// and the animation flag, walks the top-level chunks and, inside the first
// ANMF frame, finds the last ALPH subchunk before the VP8 or VP8L body.
// Exactly one result request leaves on the output stream per file, after its
// final byte: a status and the offsets and lengths the caller needs to copy
// the chunks and rebuild a still file of total_length bytes.
// Throughput is one byte per cycle unless the output stalls. A byte goes
// through an input register and the chunk-walk logic (a 33-bit add and compare
// on the header position); the result enters the output register when the core
// takes the final byte. When the receiver stalls, the result holds and bytes
// keep flowing until a second final byte arrives, which waits in the input
// register. Reset clears the parser, both valid flags and the position count;
// after each result the parser starts over for the next file.

module webp_animation_still_locator import wasl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,  // byte_in[7:0]
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  // status[1:0], alpha_offset[33:2], alpha_length[66:34], body_offset[98:67],
  // body_length[131:99], total_length[164:132], zero fill[167:165]
  output logic [TDATA_W-1:0] m_tdata
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       consume;
  result_t    core_res;
  result_t    out_res;

  assign consume = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || consume;

  wasl_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (consume),
    .byte_in (in_byte),
    .last    (in_last),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (consume && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last) begin
      out_res <= core_res;
    end
  end

  assign m_tdata = {(TDATA_W - $bits(result_t))'(0), out_res};

`ifndef NO_ASSERTIONS
  a_fields_zero_unless_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.status != ST_FOUND |->
      out_res.alpha_offset == '0 && out_res.alpha_length == '0 &&
      out_res.body_offset == '0 && out_res.body_length == '0 &&
      out_res.total_length == '0)
    else $error("result fields set on a failed or non-animated file");

  a_total_matches: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.status == ST_FOUND |->
      out_res.total_length == STILL_HDR + out_res.alpha_length + out_res.body_length &&
      out_res.body_length >= CHUNK_HDR)
    else $error("total length does not match the chunk lengths");

  a_final_byte_gives_result: assert property (@(posedge clk) disable iff (rst)
    consume && in_last |=> m_tvalid)
    else $error("final byte taken without a result");
`endif

endmodule
